FILE: rtl/assert_macros.svh
// Assertion macros used by the checker pae_checker.sv.
// Each macro samples on clk; all but ASSERT_NEXT_ALWAYS are disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication that is also checked during reset
`define ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/pae_pkg.sv
// Package for the pulsed emitter ambient compensation block.
// Holds default parameters, operation codes, cycle phases and register indexes.
`default_nettype none
package pae_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int LAST_PHASE_DEF  = 4;
  localparam int PHASE_BITS      = 3;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_CONV = 1'b1;

  localparam logic CONV_OUTER = 1'b0;
  localparam logic CONV_INNER = 1'b1;

  localparam logic [PHASE_BITS-1:0] PH_LIGHT   = 3'd0;
  localparam logic [PHASE_BITS-1:0] PH_START_A = 3'd1;
  localparam logic [PHASE_BITS-1:0] PH_DARK    = 3'd3;
  localparam logic [PHASE_BITS-1:0] PH_START_B = 3'd4;

  localparam logic REG_ENABLE = 1'b0;

  typedef struct packed {
    logic valid;
    logic opcode;
    logic converter;
  } pae_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/pulsed_emitter_ambient_compensation_top.sv
// Top level of the pulsed emitter ambient compensation block.
// Instantiates pae_regs, pae_in_reg and pae_core; depends on pae_pkg.
//
// Every transaction (timer tick or conversion done) yields exactly one result.
// Throughput is one transaction per clock while out_stall is low; a
// transaction passes the input register, then the state update, whose
// registers are also the result register. The state update sets the rate. The
// result reports the emitter level, a start pulse on ticks that enter a
// conversion phase, the four compensated levels and the four dark references.
`default_nettype none
module pulsed_emitter_ambient_compensation_top
  import pae_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int LAST_PHASE  = LAST_PHASE_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [2:0]             paddr,
  input  wire logic [31:0]            pwdata,
  output logic      [31:0]            prdata,
  output logic                        pready,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic                   opcode,
  input  wire logic                   converter,
  input  wire logic [SAMPLE_BITS-1:0] sample_rank_one,
  input  wire logic [SAMPLE_BITS-1:0] sample_rank_two,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        emitter_on,
  output logic                        start_conversion,
  output logic      [SAMPLE_BITS:0]   outer_left_level,
  output logic      [SAMPLE_BITS:0]   inner_left_level,
  output logic      [SAMPLE_BITS:0]   inner_right_level,
  output logic      [SAMPLE_BITS:0]   outer_right_level,
  output logic      [SAMPLE_BITS-1:0] outer_left_ambient,
  output logic      [SAMPLE_BITS-1:0] inner_left_ambient,
  output logic      [SAMPLE_BITS-1:0] inner_right_ambient,
  output logic      [SAMPLE_BITS-1:0] outer_right_ambient
);

  logic                   enable;
  logic                   take;
  pae_ctl_t               ctl;
  logic [SAMPLE_BITS-1:0] s1;
  logic [SAMPLE_BITS-1:0] s2;

  pae_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .enable  (enable)
  );

  pae_in_reg #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_in_reg (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .opcode          (opcode),
    .converter       (converter),
    .sample_rank_one (sample_rank_one),
    .sample_rank_two (sample_rank_two),
    .take            (take),
    .ctl             (ctl),
    .s1              (s1),
    .s2              (s2)
  );

  pae_core #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .LAST_PHASE  (LAST_PHASE)
  ) u_core (
    .clk                 (clk),
    .rst                 (rst),
    .enable              (enable),
    .ctl                 (ctl),
    .s1                  (s1),
    .s2                  (s2),
    .take                (take),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .emitter_on          (emitter_on),
    .start_conversion    (start_conversion),
    .outer_left_level    (outer_left_level),
    .inner_left_level    (inner_left_level),
    .inner_right_level   (inner_right_level),
    .outer_right_level   (outer_right_level),
    .outer_left_ambient  (outer_left_ambient),
    .inner_left_ambient  (inner_left_ambient),
    .inner_right_ambient (inner_right_ambient),
    .outer_right_ambient (outer_right_ambient)
  );

endmodule
`default_nettype wire

FILE: rtl/pae_regs.sv
// APB-style configuration register file: holds the enable bit.
// Depends on pae_pkg.
`default_nettype none
module pae_regs
  import pae_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output logic             enable
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b1;
    end else if (wr && paddr[2] == REG_ENABLE) begin
      enable <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_ENABLE) begin
      prdata = {31'b0, enable};
    end
  end

endmodule
`default_nettype wire

FILE: rtl/pae_in_reg.sv
// Input register: captures one transaction and holds it until the core takes it.
// Depends on pae_pkg.
`default_nettype none
module pae_in_reg
  import pae_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic                   opcode,
  input  wire logic                   converter,
  input  wire logic [SAMPLE_BITS-1:0] sample_rank_one,
  input  wire logic [SAMPLE_BITS-1:0] sample_rank_two,
  input  wire logic                   take,
  output pae_ctl_t                    ctl,
  output logic      [SAMPLE_BITS-1:0] s1,
  output logic      [SAMPLE_BITS-1:0] s2
);

  logic accept;

  assign in_stall = ctl.valid && !take;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (accept) begin
      ctl.valid <= 1'b1;
    end else if (take) begin
      ctl.valid <= 1'b0;
    end
    if (accept) begin
      ctl.opcode    <= opcode;
      ctl.converter <= converter;
      s1            <= sample_rank_one;
      s2            <= sample_rank_two;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/pae_core.sv
// Cycle phase, pending flags, ambient references and compensated levels.
// The state registers double as the result register. Depends on pae_pkg.
`default_nettype none
module pae_core
  import pae_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int LAST_PHASE  = LAST_PHASE_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   enable,
  input  wire pae_ctl_t               ctl,
  input  wire logic [SAMPLE_BITS-1:0] s1,
  input  wire logic [SAMPLE_BITS-1:0] s2,
  output logic                        take,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        emitter_on,
  output logic                        start_conversion,
  output logic      [SAMPLE_BITS:0]   outer_left_level,
  output logic      [SAMPLE_BITS:0]   inner_left_level,
  output logic      [SAMPLE_BITS:0]   inner_right_level,
  output logic      [SAMPLE_BITS:0]   outer_right_level,
  output logic      [SAMPLE_BITS-1:0] outer_left_ambient,
  output logic      [SAMPLE_BITS-1:0] inner_left_ambient,
  output logic      [SAMPLE_BITS-1:0] inner_right_ambient,
  output logic      [SAMPLE_BITS-1:0] outer_right_ambient
);

  localparam logic [PHASE_BITS:0]    LastPhase = (PHASE_BITS+1)'(LAST_PHASE);
  localparam logic [SAMPLE_BITS-1:0] FullScale = {SAMPLE_BITS{1'b1}};

  function automatic logic [SAMPLE_BITS:0] compensate(input logic [SAMPLE_BITS-1:0] s,
                                                      input logic [SAMPLE_BITS-1:0] r);
    logic [SAMPLE_BITS-1:0] half;
    half = (FullScale - r) >> 1;
    return {1'b0, s} + {1'b0, half};
  endfunction

  logic [PHASE_BITS-1:0] phase, phase_next;
  logic [PHASE_BITS:0]   phase_inc;
  logic                  outer_pending, outer_pending_next;
  logic                  inner_pending, inner_pending_next;
  logic                  emitter_next, start_next;

  assign take      = ctl.valid && (!out_valid || !out_stall);
  assign phase_inc = {1'b0, phase} + 1'b1;

  always_comb begin
    phase_next         = phase;
    outer_pending_next = outer_pending;
    inner_pending_next = inner_pending;
    emitter_next       = emitter_on;
    start_next         = 1'b0;
    if (ctl.opcode == OP_TICK) begin
      if (enable) begin
        phase_next = (phase_inc > LastPhase) ? '0 : phase_inc[PHASE_BITS-1:0];
        case (phase_next)
          PH_LIGHT: emitter_next = 1'b1;
          PH_START_A, PH_START_B: begin
            outer_pending_next = 1'b1;
            inner_pending_next = 1'b1;
            start_next         = 1'b1;
          end
          PH_DARK: emitter_next = 1'b0;
          default: ;
        endcase
      end
    end else if (emitter_on) begin
      if (ctl.converter == CONV_OUTER) begin
        outer_pending_next = 1'b0;
      end else begin
        inner_pending_next = 1'b0;
      end
      if (!outer_pending_next && !inner_pending_next) begin
        emitter_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid           <= 1'b0;
      phase               <= '0;
      outer_pending       <= 1'b0;
      inner_pending       <= 1'b0;
      emitter_on          <= 1'b0;
      start_conversion    <= 1'b0;
      outer_left_level    <= '0;
      inner_left_level    <= '0;
      inner_right_level   <= '0;
      outer_right_level   <= '0;
      outer_left_ambient  <= '0;
      inner_left_ambient  <= '0;
      inner_right_ambient <= '0;
      outer_right_ambient <= '0;
    end else if (take) begin
      out_valid        <= 1'b1;
      phase            <= phase_next;
      outer_pending    <= outer_pending_next;
      inner_pending    <= inner_pending_next;
      emitter_on       <= emitter_next;
      start_conversion <= start_next;
      if (ctl.opcode == OP_CONV) begin
        if (emitter_on) begin
          if (ctl.converter == CONV_OUTER) begin
            outer_left_level  <= compensate(s1, outer_left_ambient);
            outer_right_level <= compensate(s2, outer_right_ambient);
          end else begin
            inner_left_level  <= compensate(s1, inner_left_ambient);
            inner_right_level <= compensate(s2, inner_right_ambient);
          end
        end else begin
          if (ctl.converter == CONV_OUTER) begin
            outer_left_ambient  <= s1;
            outer_right_ambient <= s2;
          end else begin
            inner_left_ambient  <= s1;
            inner_right_ambient <= s2;
          end
        end
      end
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/pae_checker.sv
// Port-level checker for the pulsed emitter ambient compensation top level.
// Uses assert_macros.svh and pae_pkg; bound to the top level below.
`default_nettype none
`include "assert_macros.svh"
module pae_checker
  import pae_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   psel,
  input wire logic                   penable,
  input wire logic                   pwrite,
  input wire logic [2:0]             paddr,
  input wire logic [31:0]            prdata,
  input wire logic                   out_valid,
  input wire logic                   out_stall,
  input wire logic                   emitter_on,
  input wire logic                   start_conversion,
  input wire logic [SAMPLE_BITS:0]   outer_left_level,
  input wire logic [SAMPLE_BITS:0]   inner_right_level,
  input wire logic [SAMPLE_BITS-1:0] outer_left_ambient
);

  localparam logic [SAMPLE_BITS:0] LevelMax = {{SAMPLE_BITS{1'b1}}, 1'b0};

  logic                   levels_in_range;
  logic                   enable_read;
  logic [SAMPLE_BITS+1:0] held_view;

  assign levels_in_range = (outer_left_level <= LevelMax) && (inner_right_level <= LevelMax);
  assign enable_read     = psel && penable && !pwrite && (paddr[2] == REG_ENABLE);
  assign held_view       = {emitter_on, start_conversion, outer_left_ambient};

  `ASSERT_NEXT_ALWAYS(a_reset_clears_out, rst, !out_valid)
  `ASSERT_IMPLY(a_level_range, out_valid, levels_in_range)
  `ASSERT_IMPLY(a_prdata_upper_zero, enable_read, prdata[31:1] == 31'b0)
  `ASSERT_NEXT(a_out_held, out_valid && out_stall, out_valid)
  `ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(held_view))

endmodule

bind pulsed_emitter_ambient_compensation_top pae_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_pae_checker (
  .clk                (clk),
  .rst                (rst),
  .psel               (psel),
  .penable            (penable),
  .pwrite             (pwrite),
  .paddr              (paddr),
  .prdata             (prdata),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .emitter_on         (emitter_on),
  .start_conversion   (start_conversion),
  .outer_left_level   (outer_left_level),
  .inner_right_level  (inner_right_level),
  .outer_left_ambient (outer_left_ambient)
);
`default_nettype wire
